/* hdl/tplru_pkg.sv */
// Shared types, fixed field widths and elaboration helpers for the tree
// pseudo-LRU cache lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tplru_pkg;

  // Fixed widths of the beat fields.
  localparam int ADDR_W    = 32;
  localparam int WAY_OUT_W = 2;
  localparam int COUNT_W   = 32;

  // Sequencer states: clearing pass, waiting for a beat, row read back.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Floor of log2, used at elaboration to round sizes down to a power of two.
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/tplru_ifs.sv */
// Valid/ready channel interfaces for lookup requests and lookup results.
// Depends on tplru_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tplru_req_if;
  import tplru_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface tplru_rsp_if;
  import tplru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [COUNT_W-1:0]   access_total;
  logic [COUNT_W-1:0]   miss_total;

  modport source (output valid, output hit, output way, output access_total,
                  output miss_total, input ready);
  modport sink   (input valid, input hit, input way, input access_total,
                  input miss_total, output ready);
endinterface

`default_nettype wire

/* hdl/tree_plru_cache_lookup.sv */
// Tag store of a set-associative cache with tree pseudo-LRU replacement. Each request beat
// carries a byte address; the block splits it into offset, set and tag, looks the tag up
// among the valid ways of its set and returns one result beat with hit, way and two
// saturating totals. All state of a set (tags, valid bits, tree bits) sits in one RAM row,
// so an access reads the row in the accept cycle and writes it back in the lookup state
// once the output register is free; no new request is taken until that write-back is done.
// After reset the block clears the RAM one row per cycle, all 2**floor(log2(SETS)) rows,
// and accepts no beat until that pass is done. A result beat waits in an output register.
// Depends on tplru_pkg, tplru_ifs and tplru_ram.
`timescale 1ns / 1ps
`default_nettype none

module tree_plru_cache_lookup #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tplru_req_if.sink  req,
  tplru_rsp_if.source rsp
);
  import tplru_pkg::*;

  // Address split and row layout.
  localparam int OFF_BITS  = floor_log2(BLOCK_BYTES);
  localparam int SET_BITS  = floor_log2(SETS);
  localparam int SET_CNT   = 1 << SET_BITS;
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int TAG_BITS  = EFF_BITS - OFF_BITS - SET_BITS;
  localparam int TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int PLRU_W    = (WAYS > 1) ? WAYS - 1 : 1;
  localparam int WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NODE_W    = $clog2(2 * WAYS);
  localparam int LEVELS    = floor_log2(2 * WAYS - 1);
  localparam int TAGS_W    = WAYS * TAG_W;
  localparam int ROW_W     = PLRU_W + WAYS + TAGS_W;

  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? '1 :
      ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SET_W-1:0]   SET_MASK  = SET_W'(SET_CNT - 1);
  localparam logic [SET_W-1:0]   SET_LAST  = SET_W'(SET_CNT - 1);
  localparam logic [NODE_W-1:0]  FIRST_LEAF = NODE_W'(WAYS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Registers.
  state_t             state, state_next;
  logic [SET_W-1:0]   clr_cnt;
  logic [SET_W-1:0]   req_set;
  logic [TAG_W-1:0]   req_tag;
  logic [COUNT_W-1:0] access_cnt, access_cnt_next;
  logic [COUNT_W-1:0] miss_cnt, miss_cnt_next;
  logic               out_valid;
  logic               out_hit;
  logic [WIDX_W-1:0]  out_way;

  // Combinational signals.
  logic [ADDR_W-1:0]           addr_m;
  logic [SET_W-1:0]            in_set;
  logic [TAG_W-1:0]            in_tag;
  logic                        accept;
  logic                        out_free;
  logic                        advance;
  logic                        ram_we;
  logic [SET_W-1:0]            ram_waddr;
  logic [ROW_W-1:0]            ram_wdata;
  logic [ROW_W-1:0]            ram_rdata;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tags;
  logic [WAYS-1:0]             rd_valid;
  logic [PLRU_W-1:0]           rd_plru;
  logic                        hit;
  logic [WIDX_W-1:0]           hit_way;
  logic [WIDX_W-1:0]           found;
  logic [PLRU_W-1:0]           touch_plru;
  logic [PLRU_W-1:0]           walk_plru;
  logic [WIDX_W-1:0]           walk_way;
  logic [PLRU_W-1:0]           new_plru;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][TAG_W-1:0]  new_tags;

  // Address split of the incoming beat.
  assign addr_m = req.address & ADDR_MASK;
  assign in_set = SET_W'(addr_m >> OFF_BITS) & SET_MASK;
  assign in_tag = TAG_W'(addr_m >> (OFF_BITS + SET_BITS));

  // Handshake.
  assign out_free = !out_valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign advance  = (state == ST_LOOKUP) && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Sequencer outputs: ready and the RAM write port.
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = req_set;
    ram_wdata = {new_plru, new_valid, new_tags};
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_LOOKUP: begin
        ram_we = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // One row per set: tree bits, valid bits and tags.
  tplru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_CNT)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  assign rd_tags  = ram_rdata[TAGS_W-1:0];
  assign rd_valid = ram_rdata[TAGS_W +: WAYS];
  assign rd_plru  = ram_rdata[TAGS_W + WAYS +: PLRU_W];

  // Tag compare; the lowest matching valid way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w] && (rd_tags[w] == req_tag)) begin
        hit     = 1'b1;
        hit_way = WIDX_W'(w);
      end
    end
  end

  // On a hit, point every node on the path from the leaf up to the root at it.
  always_comb begin
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    touch_plru = rd_plru;
    parent     = '0;
    node       = NODE_W'(hit_way) + FIRST_LEAF;
    for (int l = 0; l < LEVELS; l++) begin
      if (node != '0) begin
        parent = (node - NODE_W'(1)) >> 1;
        if (node[0]) begin
          touch_plru = touch_plru | (PLRU_W'(1) << parent);
        end else begin
          touch_plru = touch_plru & ~(PLRU_W'(1) << parent);
        end
        node = parent;
      end
    end
  end

  // On a miss, invert each node on the walk from the root and follow it.
  always_comb begin
    logic [NODE_W-1:0] node;
    logic [PLRU_W-1:0] m;
    walk_plru = rd_plru;
    m         = '0;
    node      = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (node < FIRST_LEAF) begin
        m         = PLRU_W'(1) << node;
        walk_plru = walk_plru ^ m;
        if ((walk_plru & m) != '0) begin
          node = NODE_W'((node << 1) + NODE_W'(1));
        end else begin
          node = NODE_W'((node << 1) + NODE_W'(2));
        end
      end
    end
    walk_way = WIDX_W'(node - FIRST_LEAF);
  end

  // Row write-back: the victim takes the new tag and becomes valid.
  always_comb begin
    found     = hit ? hit_way : walk_way;
    new_plru  = hit ? touch_plru : walk_plru;
    new_valid = rd_valid;
    new_tags  = rd_tags;
    if (!hit) begin
      for (int w = 0; w < WAYS; w++) begin
        if (walk_way == WIDX_W'(w)) begin
          new_valid[w] = 1'b1;
          new_tags[w]  = req_tag;
        end
      end
    end
    if (WAYS == 1) begin
      new_plru = '0;
    end
  end

  // Saturating totals.
  always_comb begin
    access_cnt_next = (access_cnt == COUNT_MAX) ? access_cnt : access_cnt + COUNT_W'(1);
    miss_cnt_next   = miss_cnt;
    if (!hit && miss_cnt != COUNT_MAX) begin
      miss_cnt_next = miss_cnt + COUNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      access_cnt <= '0;
      miss_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (advance) begin
        access_cnt <= access_cnt_next;
        miss_cnt   <= miss_cnt_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request hold and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_set <= in_set;
      req_tag <= in_tag;
    end
    if (advance) begin
      out_hit <= hit;
      out_way <= found;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.way          = WAY_OUT_W'(out_way);
  assign rsp.access_total = access_cnt;
  assign rsp.miss_total   = miss_cnt;

endmodule

`default_nettype wire

/* hdl/tplru_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
